### sv/nvs_pkg.sv
package nvs_pkg;

   // Default sizing
   localparam int DEF_MAX_DIM        = 256;
   localparam int DEF_MAX_CANDIDATES = 65536;

   // Bound loaded at reset
   localparam logic [31:0] RESET_BOUND = 32'd100000;

   // Command codes on the request channel
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CAND  = 2'd2;

   // Datapath widths
   localparam int ACC_W = 48;
   localparam int SQ_W  = 32;

   // Result queue sizing
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W      = 3;
   localparam int RSP_CNT_W      = 4;

   typedef logic [31:0] bound_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] value;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] candidate_index;
      logic [31:0] candidate_distance;
      logic [31:0] best_distance;
      logic [15:0] best_index;
      logic        found;
   } rsp_payload_type;

   // Control carried alongside each item through the pipeline
   typedef struct packed {
      logic valid;
      logic clear;   // clear search
      logic qend;    // last element of a query
      logic cand;    // candidate element
      logic last;    // final element of the candidate
      logic use_el;  // element lies inside the query length
      logic match;   // candidate length equals query length
   } stage_ctl_type;

endpackage

### sv/nvs_stream_if.sv
interface nvs_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/nvs_rsp_fifo.sv
module nvs_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  nvs_pkg::rsp_payload_type push_data,
   output logic [nvs_pkg::RSP_CNT_W-1:0] fill,
   nvs_stream_if.source             rsp_if
);
   import nvs_pkg::*;

   rsp_payload_type          queue_mem [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]     count_ff, count_in;
   logic                     pop;

   // Head of the queue drives the result channel
   assign rsp_if.valid   = (count_ff != '0);
   assign rsp_if.payload = queue_mem[rd_ptr_ff];
   assign pop            = rsp_if.valid && rsp_if.ready;
   assign fill           = count_ff;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/nearest_vector_search_l2_core.sv
// Brute-force nearest-neighbour search, squared Euclidean distance, Q8.8.
// req_if: one element per transfer. cmd clear resets the search state,
//   query elements fill the query store (last ends the query), candidate
//   elements accumulate the squared distance to the stored query.
// rsp_if: one result per candidate, on its last element: index, distance
//   (integer part), best distance, best index and found flag.
// csr_if: single write channel for the bound loaded on clear; always ready.
//   Write it only while no item is in flight.
// Throughput: one element per cycle while req_if.ready is high, set by the
//   query store read and one square and one 48-bit add per pipeline stage.
// A result becomes valid once the candidate's last element, after its
//   transfer, has passed store read, square, accumulate and compare/queue.
// Reset clears all control state, the query length and the best distance
//   (bound returns to 100000); the query store contents are not cleared.
// When rsp_if stalls, results collect in an 8-entry queue; req_if.ready
//   drops only once the queue plus results still in the pipeline fill it.
module nearest_vector_search_l2_core #(
   parameter int MAX_DIM        = nvs_pkg::DEF_MAX_DIM,
   parameter int MAX_CANDIDATES = nvs_pkg::DEF_MAX_CANDIDATES
) (
   input  logic          clock,
   input  logic          reset,
   nvs_stream_if.sink    req_if,
   nvs_stream_if.source  rsp_if,
   nvs_stream_if.sink    csr_if
);
   import nvs_pkg::*;

   localparam int PW = $clog2(MAX_DIM + 1);
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW = $clog2(MAX_CANDIDATES);
   localparam logic [PW-1:0] DIM_P   = PW'(MAX_DIM);
   localparam logic [CW-1:0] CNT_TOP = CW'(MAX_CANDIDATES - 1);

   // ---------------------------------------------------------------
   // Configuration register
   bound_type bound_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= RESET_BOUND;
      end else if (csr_if.valid) begin
         bound_ff <= csr_if.payload;
      end
   end

   // ---------------------------------------------------------------
   // Intake: position tracking, query store write, store read
   req_payload_type    req;
   logic               req_ready;
   logic               req_fire;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      qlen_ff, qlen_in;
   logic [PW-1:0]      pos_inc;
   logic [PW:0]        cand_len;
   logic signed [15:0] store_mem [MAX_DIM];
   logic signed [15:0] qdat_ff;
   logic signed [15:0] s1_value_ff;
   stage_ctl_type      s1_ctl_ff, s1_ctl_in;
   logic [RSP_CNT_W-1:0] fill;
   logic [RSP_CNT_W-1:0] pending;

   assign req       = req_if.payload;
   assign req_fire  = req_if.valid && req_ready;
   assign pos_inc   = (pos_ff < DIM_P) ? pos_ff + 1'b1 : pos_ff;
   assign cand_len  = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      pos_in    = pos_ff;
      qlen_in   = qlen_ff;
      s1_ctl_in = '0;
      if (req_fire) begin
         unique case (req.cmd)
            CMD_CLEAR: begin
               pos_in          = '0;
               s1_ctl_in.valid = 1'b1;
               s1_ctl_in.clear = 1'b1;
            end
            CMD_QUERY: begin
               if (req.last) begin
                  qlen_in         = pos_inc;
                  pos_in          = '0;
                  s1_ctl_in.valid = 1'b1;
                  s1_ctl_in.qend  = 1'b1;
               end else begin
                  pos_in = pos_inc;
               end
            end
            CMD_CAND: begin
               pos_in           = req.last ? '0 : pos_inc;
               s1_ctl_in.valid  = 1'b1;
               s1_ctl_in.cand   = 1'b1;
               s1_ctl_in.last   = req.last;
               s1_ctl_in.use_el = (pos_ff < qlen_ff);
               s1_ctl_in.match  = (cand_len == {1'b0, qlen_ff});
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         qlen_ff   <= '0;
         s1_ctl_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         qlen_ff   <= qlen_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // Query store: written by query elements, read for candidate elements
   always_ff @(posedge clock) begin
      if (req_fire && (req.cmd == CMD_QUERY) && (pos_ff < DIM_P)) begin
         store_mem[pos_ff[AW-1:0]] <= req.value;
      end
      if (req_fire && (req.cmd == CMD_CAND)) begin
         qdat_ff <= store_mem[pos_ff[AW-1:0]];
      end
      s1_value_ff <= req.value;
   end

   // ---------------------------------------------------------------
   // Stage 1: difference and square
   logic signed [16:0] diff;
   logic signed [33:0] prod;
   logic [SQ_W-1:0]    sq;
   stage_ctl_type      s2_ctl_ff;
   logic [SQ_W-1:0]    s2_sq_ff;

   assign diff = {qdat_ff[15], qdat_ff} - {s1_value_ff[15], s1_value_ff};
   assign prod = diff * diff;
   assign sq   = s1_ctl_ff.use_el ? prod[SQ_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_sq_ff <= sq;
   end

   // ---------------------------------------------------------------
   // Stage 2: saturating accumulate
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W:0]   acc_sum;
   logic [ACC_W-1:0] acc_sat;
   stage_ctl_type    s3_ctl_ff;
   logic [ACC_W-1:0] s3_total_ff;

   assign acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(s2_sq_ff);
   assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (s2_ctl_ff.valid) begin
         if (s2_ctl_ff.clear || s2_ctl_ff.qend || s2_ctl_ff.last) begin
            acc_in = '0;
         end else begin
            acc_in = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         s3_ctl_ff <= '0;
      end else begin
         acc_ff    <= acc_in;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_total_ff <= acc_sat;
   end

   // ---------------------------------------------------------------
   // Stage 3: integer distance, best tracking, result push
   logic [31:0]     cand_dist;
   logic            better;
   logic            push;
   logic [31:0]     best_ff, best_in;
   logic [CW-1:0]   best_pos_ff, best_pos_in;
   logic            found_ff, found_in;
   logic [CW-1:0]   cand_cnt_ff, cand_cnt_in;
   rsp_payload_type push_data;

   // The top 32 bits of the 48-bit sum are the integer part
   assign cand_dist = s3_ctl_ff.match ? s3_total_ff[ACC_W-1:ACC_W-32] : '0;
   assign better    = (cand_dist < best_ff);
   assign push      = s3_ctl_ff.valid && s3_ctl_ff.cand && s3_ctl_ff.last;

   always_comb begin
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      found_in    = found_ff;
      cand_cnt_in = cand_cnt_ff;
      if (s3_ctl_ff.valid) begin
         if (s3_ctl_ff.clear) begin
            best_in     = bound_ff;
            best_pos_in = '0;
            found_in    = 1'b0;
            cand_cnt_in = '0;
         end else if (s3_ctl_ff.qend) begin
            cand_cnt_in = '0;
         end else if (push) begin
            if (better) begin
               best_in     = cand_dist;
               best_pos_in = cand_cnt_ff;
               found_in    = 1'b1;
            end
            cand_cnt_in = (cand_cnt_ff == CNT_TOP) ? '0 : cand_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff     <= RESET_BOUND;
         best_pos_ff <= '0;
         found_ff    <= 1'b0;
         cand_cnt_ff <= '0;
      end else begin
         best_ff     <= best_in;
         best_pos_ff <= best_pos_in;
         found_ff    <= found_in;
         cand_cnt_ff <= cand_cnt_in;
      end
   end

   always_comb begin
      push_data.candidate_index    = 16'(cand_cnt_ff);
      push_data.candidate_distance = cand_dist;
      push_data.best_distance      = best_in;
      push_data.best_index         = 16'(best_pos_in);
      push_data.found              = found_in;
   end

   // ---------------------------------------------------------------
   // Result queue and intake credit
   nvs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .fill      (fill),
      .rsp_if    (rsp_if)
   );

   // Results still in the pipeline must find room in the queue
   assign pending = RSP_CNT_W'(s1_ctl_ff.cand && s1_ctl_ff.last)
                  + RSP_CNT_W'(s2_ctl_ff.cand && s2_ctl_ff.last)
                  + RSP_CNT_W'(s3_ctl_ff.cand && s3_ctl_ff.last);
   assign req_ready    = ((fill + pending) < RSP_CNT_W'(RSP_FIFO_DEPTH));
   assign req_if.ready = req_ready;

endmodule
